// ===== hdl/rssi_presence_detector_assert.svh =====
// Assertion macros used by the detector top module.
`ifndef RSSI_PRESENCE_DETECTOR_ASSERT_SVH
`define RSSI_PRESENCE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rpd_pkg.sv =====
package rpd_pkg;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned RssiW   = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 64;

  typedef enum logic {
    OP_REPORT   = 1'b0,
    OP_EVALUATE = 1'b1
  } rpd_op_e;

  typedef enum logic [1:0] {
    REG_TARGET_ADDRESS = 2'd0,
    REG_RSSI_FLOOR     = 2'd1,
    REG_RSSI_CEIL      = 2'd2,
    REG_ABSENCE_WINDOW = 2'd3
  } rpd_reg_e;

  // Register reset values
  localparam logic [AddrW-1:0]   TargetAddrRst = '0;
  localparam logic [RssiW-1:0]   RssiFloorRst  = 8'hB0;  // -80 dBm
  localparam logic [RssiW-1:0]   RssiCeilRst   = 8'hC4;  // -60 dBm
  localparam logic [WindowW-1:0] WindowRst     = 16'd3000;

  // Mean before any sighting: -127 dBm
  localparam logic [RssiW-1:0] AvgRst = 8'h81;

  // x/3 == (x*171) >> 9 for every magnitude the ring sum can reach
  localparam logic [8:0]  RecipThree = 9'd171;
  localparam int unsigned RecipShift = 9;

  typedef struct packed {
    logic [AddrW-1:0]   target_address;
    logic [RssiW-1:0]   rssi_floor;
    logic [RssiW-1:0]   rssi_ceil;
    logic [WindowW-1:0] absence_window_ms;
  } rpd_cfg_t;

  typedef struct packed {
    logic present;
    logic entry;
    logic exit_p;
  } rpd_pres_t;

endpackage

// ===== hdl/rpd_if.sv =====
// Request channel: one report or evaluate item.
interface rpd_req_if import rpd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [AddrW-1:0]         sender_address;
  logic signed [RssiW-1:0]  sample_rssi;
  logic [TimeW-1:0]         now_ms;

  modport source (output valid, operation, sender_address, sample_rssi, now_ms,
                  input ready);
  modport sink   (input valid, operation, sender_address, sample_rssi, now_ms,
                  output ready);
endinterface

// Result channel: one result per request.
interface rpd_rsp_if import rpd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     address_matched;
  logic signed [RssiW-1:0]  smoothed_rssi;
  logic                     is_present;
  logic                     entry_pulse;
  logic                     exit_pulse;

  modport source (output valid, address_matched, smoothed_rssi, is_present,
                  entry_pulse, exit_pulse, input ready);
  modport sink   (input valid, address_matched, smoothed_rssi, is_present,
                  entry_pulse, exit_pulse, output ready);
endinterface

// ===== hdl/rssi_presence_detector.sv =====
// Channel   Role    Payload
// req_i     sink    operation, sender_address, sample_rssi, now_ms
// rsp_o     source  address_matched, smoothed_rssi, is_present, entry_pulse, exit_pulse
// APB       slave   target_address 0x00, band floor 0x08, band ceiling 0x10, absence_window 0x18
//
// One request per cycle unless the result channel stalls; an accepted request
// is held in the request register. The ring mean and the presence decision are
// combinational logic between the request register and the result register.
// Reset loads register defaults and clears ring control and presence state.
// A stalled result holds; one more request is taken into the request register.
`include "rssi_presence_detector_assert.svh"

module rssi_presence_detector import rpd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rpd_req_if.sink           req_i,
  rpd_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  rpd_cfg_t cfg;

  logic                    in_valid_q;
  rpd_op_e                 op_q;
  logic [AddrW-1:0]        sender_q;
  logic signed [RssiW-1:0] sample_q;
  logic [TimeW-1:0]        now_q;

  logic                    out_valid_q;
  logic                    matched_q;
  logic signed [RssiW-1:0] smoothed_q;
  logic                    present_q;
  logic                    entry_q;
  logic                    exit_q;

  logic                    advance;
  logic                    in_take;
  logic                    matched;
  logic signed [RssiW-1:0] avg_next;
  logic signed [RssiW-1:0] avg_cur;
  rpd_pres_t               pres;

  rpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a request forward when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready   = !in_valid_q || advance;
  assign in_take       = req_i.valid && req_i.ready;
  assign matched       = (op_q == OP_REPORT) && (sender_q == cfg.target_address);

  rpd_ring_avg #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (advance && matched),
    .sample_i   (sample_q),
    .avg_next_o (avg_next),
    .avg_q_o    (avg_cur)
  );

  rpd_presence u_pres (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .op_i    (op_q),
    .match_i (matched),
    .now_i   (now_q),
    .avg_i   (avg_cur),
    .cfg_i   (cfg),
    .pres_o  (pres)
  );

  // Request register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Request register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= rpd_op_e'(req_i.operation);
      sender_q <= req_i.sender_address;
      sample_q <= req_i.sample_rssi;
      now_q    <= req_i.now_ms;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      matched_q  <= matched;
      smoothed_q <= matched ? avg_next : avg_cur;
      present_q  <= pres.present;
      entry_q    <= pres.entry;
      exit_q     <= pres.exit_p;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.address_matched = matched_q;
  assign rsp_o.smoothed_rssi   = smoothed_q;
  assign rsp_o.is_present      = present_q;
  assign rsp_o.entry_pulse     = entry_q;
  assign rsp_o.exit_pulse      = exit_q;

  `RPD_ASSERT_IMPL(a_pulse_excl, clk_i, rst_ni, out_valid_q, !(entry_q && exit_q), "entry and exit in one result")
  `RPD_ASSERT_IMPL(a_entry_present, clk_i, rst_ni, out_valid_q && entry_q, present_q, "entry without presence")
  `RPD_ASSERT_IMPL(a_exit_absent, clk_i, rst_ni, out_valid_q && exit_q, !present_q, "exit while still present")
  `RPD_ASSERT_IMPL(a_match_no_pulse, clk_i, rst_ni, out_valid_q && matched_q, !entry_q && !exit_q, "pulse on a report")
  `RPD_ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q, "advanced request left no result")

endmodule

// ===== hdl/rpd_cfg_regs.sv =====
module rpd_cfg_regs import rpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output rpd_cfg_t          cfg_o
);

  rpd_cfg_t cfg_q;
  rpd_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = rpd_reg_e'(paddr[PaddrW-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_address    <= TargetAddrRst;
      cfg_q.rssi_floor        <= RssiFloorRst;
      cfg_q.rssi_ceil         <= RssiCeilRst;
      cfg_q.absence_window_ms <= WindowRst;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TARGET_ADDRESS: cfg_q.target_address    <= pwdata[AddrW-1:0];
        REG_RSSI_FLOOR:     cfg_q.rssi_floor        <= pwdata[RssiW-1:0];
        REG_RSSI_CEIL:      cfg_q.rssi_ceil         <= pwdata[RssiW-1:0];
        REG_ABSENCE_WINDOW: cfg_q.absence_window_ms <= pwdata[WindowW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      REG_TARGET_ADDRESS: prdata = PdataW'(cfg_q.target_address);
      REG_RSSI_FLOOR:     prdata = PdataW'(cfg_q.rssi_floor);
      REG_RSSI_CEIL:      prdata = PdataW'(cfg_q.rssi_ceil);
      REG_ABSENCE_WINDOW: prdata = PdataW'(cfg_q.absence_window_ms);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/rpd_ring_avg.sv =====
module rpd_ring_avg import rpd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic signed [RssiW-1:0] sample_i,
  output logic signed [RssiW-1:0] avg_next_o,
  output logic signed [RssiW-1:0] avg_q_o
);

  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SumW  = RssiW + CntW;
  localparam int unsigned ProdW = SumW + 9;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(HISTORY_DEPTH);

  logic [RssiW-1:0] ring_q [HISTORY_DEPTH];
  logic [SlotW-1:0] slot_q, slot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RssiW-1:0] avg_q;
  logic [RssiW-1:0] slot_val;
  logic [SumW-1:0]  sum;
  logic             neg;
  logic [SumW-1:0]  mag;
  logic [ProdW-1:0] prod;
  logic [SumW-1:0]  quot;
  logic [1:0]       cnt_sel;

  // Advance the write slot and the fill count
  always_comb begin
    cnt_d  = (cnt_q == FullCnt) ? cnt_q : cnt_q + 1'b1;
    slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  end

  // Sum the filled entries with the new sample in place
  always_comb begin
    sum = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      slot_val = (SlotW'(i) == slot_q) ? sample_i : ring_q[i];
      if (CntW'(i) < cnt_d) begin
        sum = sum + {{CntW{slot_val[RssiW-1]}}, slot_val};
      end
    end
  end

  // Divide by the fill count, truncating toward zero
  always_comb begin
    neg     = sum[SumW-1];
    mag     = neg ? (~sum + 1'b1) : sum;
    prod    = ProdW'(mag) * ProdW'(RecipThree);
    cnt_sel = 2'(cnt_d);
    case (cnt_sel)
      2'd1:    quot = mag;
      2'd2:    quot = mag >> 1;
      default: quot = SumW'(prod >> RecipShift);
    endcase
    avg_next_o = neg ? $signed(~quot[RssiW-1:0] + 1'b1) : $signed(quot[RssiW-1:0]);
  end

  assign avg_q_o = $signed(avg_q);

  // Hold ring control and mean across items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
      avg_q  <= AvgRst;
    end else if (push_i) begin
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      avg_q  <= avg_next_o;
    end
  end

  // Store the sample; entries are read only once filled
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ring_q[slot_q] <= sample_i;
    end
  end

endmodule

// ===== hdl/rpd_presence.sv =====
module rpd_presence import rpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  rpd_op_e                 op_i,
  input  logic                    match_i,
  input  logic [TimeW-1:0]        now_i,
  input  logic signed [RssiW-1:0] avg_i,
  input  rpd_cfg_t                cfg_i,
  output rpd_pres_t               pres_o
);

  logic [TimeW-1:0] last_q;
  logic             seen_q;
  logic             present_q;
  logic [TimeW-1:0] elapsed;
  logic             in_window;
  logic             recent;
  logic             close;

  // Elapsed time wraps with the timestamp
  assign elapsed   = now_i - last_q;
  assign in_window = elapsed <= TimeW'(cfg_i.absence_window_ms);
  assign recent    = seen_q && in_window;
  assign close     = (avg_i >= $signed(cfg_i.rssi_floor)) && (avg_i <= $signed(cfg_i.rssi_ceil));

  // Enter on recent and close, drop only once the window has run out
  always_comb begin
    pres_o.present = present_q;
    pres_o.entry   = 1'b0;
    pres_o.exit_p  = 1'b0;
    if (op_i == OP_EVALUATE) begin
      if (recent && close) begin
        if (!present_q) begin
          pres_o.present = 1'b1;
          pres_o.entry   = 1'b1;
        end
      end else if (present_q && !in_window) begin
        pres_o.present = 1'b0;
        pres_o.exit_p  = 1'b1;
      end
    end
  end

  // Record sightings and presence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      seen_q    <= 1'b0;
      present_q <= 1'b0;
    end else if (step_i) begin
      present_q <= pres_o.present;
      if (match_i) begin
        last_q <= now_i;
        seen_q <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rpd_pkg::*;

  localparam int unsigned HISTORY_DEPTH  = 3;
  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  // Margin after the last result is in
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned PHASE_REQUESTS = 105;
  localparam int unsigned NUM_PHASES     = 6;

  typedef struct packed {
    logic                    matched;
    logic signed [RssiW-1:0] smoothed;
    logic                    present;
    logic                    entry;
    logic                    leave;
  } presence_t;

  // Presence predictor plus the queue of results it still owes
  class presence_scoreboard;
    logic [AddrW-1:0]   target;
    int                 rssi_lo;
    int                 rssi_hi;
    logic [WindowW-1:0] window_ms;

    int                 ring [HISTORY_DEPTH];
    int unsigned        slot;
    int unsigned        filled;
    int                 mean_dbm;
    logic [TimeW-1:0]   last_seen_ms;
    bit                 seen;
    bit                 present;

    presence_t          expected_q [$];
    int unsigned        errors;

    function new();
      target       = '0;
      rssi_lo      = -80;
      rssi_hi      = -60;
      window_ms    = 16'd3000;
      foreach (ring[i]) ring[i] = 0;
      slot         = 0;
      filled       = 0;
      mean_dbm     = -127;
      last_seen_ms = '0;
      seen         = 1'b0;
      present      = 1'b0;
      errors       = 0;
    endfunction

    function void set_register(rpd_reg_e idx, logic [PdataW-1:0] value);
      case (idx)
        REG_TARGET_ADDRESS: target = value[AddrW-1:0];
        REG_RSSI_FLOOR:     rssi_lo = int'($signed(value[RssiW-1:0]));
        REG_RSSI_CEIL:      rssi_hi = int'($signed(value[RssiW-1:0]));
        REG_ABSENCE_WINDOW: window_ms = value[WindowW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the predicted state for one accepted request
    function void note_request(rpd_op_e op, logic [AddrW-1:0] sender,
                               logic signed [RssiW-1:0] level, logic [TimeW-1:0] now);
      presence_t        exp;
      int               sum;
      logic [TimeW-1:0] elapsed;
      bit               recent;
      bit               close;
      exp = '0;
      if (op == OP_REPORT) begin
        if (sender == target) begin
          exp.matched  = 1'b1;
          last_seen_ms = now;
          seen         = 1'b1;
          ring[slot]   = int'(level);
          slot         = (slot == HISTORY_DEPTH - 1) ? 0 : slot + 1;
          if (filled < HISTORY_DEPTH) filled++;
          sum = 0;
          for (int i = 0; i < filled; i++) sum += ring[i];
          mean_dbm = sum / int'(filled);
        end
      end else begin
        elapsed = now - last_seen_ms;
        recent  = seen && (elapsed <= TimeW'(window_ms));
        close   = (mean_dbm >= rssi_lo) && (mean_dbm <= rssi_hi);
        if (recent && close) begin
          if (!present) begin
            present   = 1'b1;
            exp.entry = 1'b1;
          end
        end else if (present && elapsed > TimeW'(window_ms)) begin
          present   = 1'b0;
          exp.leave = 1'b1;
        end
      end
      exp.smoothed = mean_dbm[RssiW-1:0];
      exp.present  = present;
      expected_q.push_back(exp);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(presence_t got);
      presence_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.matched !== exp.matched) begin
        $error("address_matched expected %0d actual %0d", exp.matched, got.matched);
        errors++;
      end
      if (got.smoothed !== exp.smoothed) begin
        $error("smoothed_rssi expected %0d actual %0d",
               $signed(exp.smoothed), $signed(got.smoothed));
        errors++;
      end
      if (got.present !== exp.present) begin
        $error("is_present expected %0d actual %0d", exp.present, got.present);
        errors++;
      end
      if (got.entry !== exp.entry) begin
        $error("entry_pulse expected %0d actual %0d", exp.entry, got.entry);
        errors++;
      end
      if (got.leave !== exp.leave) begin
        $error("exit_pulse expected %0d actual %0d", exp.leave, got.leave);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  rpd_req_if req_bus ();
  rpd_rsp_if rsp_bus ();

  presence_scoreboard sb;
  int unsigned        src_idle_pct;
  int unsigned        sink_idle_pct;
  int unsigned        cycle_count = 0;
  logic [TimeW-1:0]   stamp_ms;

  rssi_presence_detector #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Observe both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        sb.note_request(rpd_op_e'(req_bus.operation), req_bus.sender_address,
                        req_bus.sample_rssi, req_bus.now_ms);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_result('{matched:  rsp_bus.address_matched,
                          smoothed: rsp_bus.smoothed_rssi,
                          present:  rsp_bus.is_present,
                          entry:    rsp_bus.entry_pulse,
                          leave:    rsp_bus.exit_pulse});
      end
    end
  end

  // Drive one request, with random idle cycles ahead of it
  task automatic send_request(rpd_op_e op, logic [AddrW-1:0] sender,
                              logic signed [RssiW-1:0] level, logic [TimeW-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid          <= 1'b1;
    req_bus.operation      <= op;
    req_bus.sender_address <= sender;
    req_bus.sample_rssi    <= level;
    req_bus.now_ms         <= now;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Hold off until every result is in and the pipeline is empty
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(rpd_reg_e idx, logic [PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Random reports and evaluations, mostly from the target, with timestamps around the absence window
  task automatic run_random(int unsigned quota);
    int unsigned        counted;
    int unsigned        pick;
    int unsigned        win;
    rpd_op_e            op;
    logic [AddrW-1:0]   sender;
    logic signed [RssiW-1:0] level;
    logic [TimeW-1:0]   now;
    counted = 0;
    while (counted < quota) begin
      win = sb.window_ms;
      op  = ($urandom_range(99) < 55) ? OP_REPORT : OP_EVALUATE;

      pick = $urandom_range(99);
      if (pick < 60) sender = sb.target;
      else if (pick < 75) sender = sb.target ^ (48'h1 << $urandom_range(AddrW - 1));
      else sender = AddrW'({$urandom, $urandom});

      if (sb.rssi_lo <= sb.rssi_hi && $urandom_range(99) < 65)
        level = RssiW'(sb.rssi_lo + int'($urandom_range(sb.rssi_hi - sb.rssi_lo)));
      else
        level = RssiW'($urandom);

      pick = $urandom_range(99);
      if (pick < 45) stamp_ms += $urandom_range(win / 2);
      else if (pick < 80) stamp_ms += $urandom_range(win + 2, win / 2);
      else if (pick < 95) stamp_ms += win + $urandom_range(5000, 1);
      else stamp_ms = $urandom;
      now = stamp_ms;

      // Land right on the edge of the absence window now and then
      if (op == OP_EVALUATE && $urandom_range(9) == 0)
        now = sb.last_seen_ms + win + $urandom_range(1);

      counted++;
      send_request(op, sender, level, now);
    end
  endtask

  initial begin
    logic [AddrW-1:0]   tgt;
    int                 lo;
    int                 hi;
    logic [WindowW-1:0] win;

    sb = new();
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_bus.valid          = 1'b0;
    req_bus.operation      = OP_REPORT;
    req_bus.sender_address = '0;
    req_bus.sample_rssi    = '0;
    req_bus.now_ms         = '0;
    rsp_bus.ready          = 1'b0;
    src_idle_pct           = 34;
    sink_idle_pct          = 48;
    stamp_ms               = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset settings (target address zero)
    send_request(OP_EVALUATE, '0, '0, 32'd0);                      // never seen
    send_request(OP_REPORT, 48'hFFFF_FFFF_FFFF, -8'sd128, 32'd5);  // other sender
    send_request(OP_REPORT, '0, -8'sd128, 32'd100);
    send_request(OP_REPORT, '0, 8'sd127, 32'd200);                 // mean truncates to 0
    send_request(OP_REPORT, '0, -8'sd70, 32'd300);
    send_request(OP_REPORT, '0, -8'sd70, 32'd400);                 // ring wraps
    send_request(OP_REPORT, '0, -8'sd70, 32'd500);
    send_request(OP_EVALUATE, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'd600); // entry
    send_request(OP_EVALUATE, '0, -8'sd128, 32'd3500);             // window edge, stays
    send_request(OP_REPORT, '0, 8'sd0, 32'd3600);                  // leaves the band
    send_request(OP_EVALUATE, '0, '0, 32'd3700);                   // present, not close
    send_request(OP_EVALUATE, '0, '0, 32'd6601);                   // exit
    send_request(OP_EVALUATE, '0, '0, 32'd6700);
    send_request(OP_REPORT, '0, -8'sd60, 32'hFFFF_FF00);
    send_request(OP_REPORT, '0, -8'sd60, 32'hFFFF_FF80);
    send_request(OP_REPORT, '0, -8'sd80, 32'hFFFF_FFFF);
    send_request(OP_EVALUATE, '0, '0, 32'h0000_0100);              // across the wrap
    send_request(OP_EVALUATE, '0, '0, 32'h0000_0BB7);
    send_request(OP_EVALUATE, '0, '0, 32'hFFFF_FFFE);              // long gone
    send_request(OP_REPORT, 48'h8000_0000_0000, 8'sd127, 32'd0);
    send_request(OP_REPORT, '0, 8'sd127, 32'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          tgt = AddrW'({$urandom, $urandom}); lo = -80; hi = -60; win = 16'd3000;
        end
        1: begin
          tgt = 48'hFFFF_FFFF_FFFF; lo = -128; hi = 127; win = 16'd0;
        end
        2: begin
          // inverted band: nothing counts as close
          tgt = AddrW'({$urandom, $urandom}); lo = 10; hi = -10; win = 16'hFFFF;
        end
        3: begin
          tgt = '0; lo = -128; hi = -128; win = 16'd1;
        end
        4: begin
          tgt = AddrW'({$urandom, $urandom}); lo = 127; hi = 127; win = WindowW'($urandom);
        end
        default: begin
          tgt = AddrW'({$urandom, $urandom}); lo = -90; hi = -50; win = 16'd500;
        end
      endcase
      write_reg(REG_TARGET_ADDRESS, PdataW'(tgt));
      write_reg(REG_RSSI_FLOOR, PdataW'(lo));
      write_reg(REG_RSSI_CEIL, PdataW'(hi));
      write_reg(REG_ABSENCE_WINDOW, PdataW'(win));

      if (p < 2) begin
        src_idle_pct  = 34;
        sink_idle_pct = 48;
      end else if (p < 4) begin
        src_idle_pct  = 48;
        sink_idle_pct = 34;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      // Start some phases just short of the timestamp wrap
      if (p == 2 || p == 5) stamp_ms = 32'hFFFF_FFFF - $urandom_range(20000);
      run_random(PHASE_REQUESTS);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
